// File: src/hmt_pkg.sv
`default_nettype none
package hmt_pkg;
  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned CNT_W = 6;

  localparam logic [1:0] CMD_MERGE = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_LIST  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_UNCHANGED = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_LIVE      = 3'd5;
  localparam logic [2:0] ST_DONE      = 3'd6;

  localparam logic [15:0] FAIL_RST   = 16'd5;
  localparam logic [15:0] REMOVE_RST = 16'd20;

  localparam logic ADDR_FAIL   = 1'b0;
  localparam logic ADDR_REMOVE = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] member_id;
    logic [15:0] member_port;
    logic [31:0] member_heartbeat;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry_id;
    logic [15:0] entry_port;
    logic [31:0] entry_heartbeat;
    logic [31:0] local_clock;
    logic [5:0]  member_count;
    logic        last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word, clear scan state
    logic count;     // count removals ahead of a tick, advance index
    logic scan;      // examine current slot, advance index
    logic fin_merge; // apply merge decision
    logic fin_tick;  // advance clock
    logic emit;      // write output register from slot
    logic emit_done; // write done/merge result to output
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // current index is the final slot
    logic slot_hit;   // current slot produces a result
  } sts_t;
endpackage
`default_nettype wire

// File: src/hmt_if.sv
`default_nettype none
interface hmt_in_if;
  logic valid;
  logic ready;
  hmt_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hmt_out_if;
  logic valid;
  logic ready;
  hmt_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/hmt_ctrl.sv
`default_nettype none
module hmt_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  output logic             out_valid,
  input  wire logic        out_ready,
  output hmt_pkg::cmd_t    cmd,
  input  hmt_pkg::sts_t    sts
);
  import hmt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_COUNT = 6'b000010,
    S_SCAN  = 6'b000100,
    S_EMIT  = 6'b001000,
    S_FIN   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic ovalid_r, ovalid_nxt;
  logic scan_end_r, scan_end_nxt;

  assign in_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    ovalid_nxt   = ovalid_r && !out_ready;
    scan_end_nxt = scan_end_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load     = 1'b1;
          cmd_nxt      = in_command;
          scan_end_nxt = 1'b0;
          if (in_command == CMD_TICK) state_nxt = S_COUNT;
          else if (in_command == CMD_MERGE || in_command == CMD_LIST) state_nxt = S_SCAN;
          else state_nxt = S_DONE;
        end
      end
      S_COUNT: begin
        // the final count goes out with every removal word
        cmd.count = 1'b1;
        if (sts.scan_last) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan     = 1'b1;
        scan_end_nxt = sts.scan_last;
        if (sts.slot_hit && cmd_r != CMD_MERGE) state_nxt = S_EMIT;
        else if (sts.scan_last) state_nxt = S_FIN;
      end
      S_EMIT: begin
        // hold the slot word until the output register is free
        if (!ovalid_r || out_ready) begin
          cmd.emit   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = scan_end_r ? S_FIN : S_SCAN;
        end
      end
      S_FIN: begin
        cmd.fin_merge = (cmd_r == CMD_MERGE);
        cmd.fin_tick  = (cmd_r == CMD_TICK);
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || out_ready) begin
          cmd.emit_done = 1'b1;
          ovalid_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ovalid_r   <= 1'b0;
      cmd_r      <= CMD_MERGE;
      scan_end_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ovalid_r   <= ovalid_nxt;
      cmd_r      <= cmd_nxt;
      scan_end_r <= scan_end_nxt;
    end
  end
endmodule
`default_nettype wire

// File: src/hmt_dp.sv
`default_nettype none
module hmt_dp #(
  parameter int unsigned TABLE_DEPTH = hmt_pkg::DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  hmt_pkg::in_word_t  in_word,
  input  hmt_pkg::cmd_t      cmd,
  output hmt_pkg::sts_t      sts,
  output hmt_pkg::out_word_t out_word,
  input  wire logic [15:0]   fail_timeout,
  input  wire logic [15:0]   remove_timeout
);
  import hmt_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [31:0] id_r [TABLE_DEPTH];
  logic [15:0] port_r [TABLE_DEPTH];
  logic [31:0] hb_r [TABLE_DEPTH];
  logic [31:0] stamp_r [TABLE_DEPTH];

  logic [31:0] clock_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] fin_cnt_r;
  in_word_t word_r;
  logic [IW-1:0] idx_r;
  logic hit_found_r, free_found_r;
  logic [IW-1:0] hit_r, free_r;
  out_word_t out_r;

  logic [31:0] age;
  logic cur_valid, id_eq, is_live, is_old, slot_hit;
  logic [31:0] h_age;
  logic upd;

  assign cur_valid = valid_r[idx_r];
  assign age       = clock_r - stamp_r[idx_r];
  assign id_eq     = id_r[idx_r] == word_r.member_id;
  assign is_live   = age <= {16'd0, fail_timeout};
  assign is_old    = age >= {16'd0, remove_timeout};

  always_comb begin
    slot_hit = 1'b0;
    if (word_r.command == CMD_TICK) slot_hit = cur_valid && is_old;
    else if (word_r.command == CMD_LIST) slot_hit = cur_valid && is_live && !id_eq;
  end

  assign sts.slot_hit  = slot_hit;
  assign sts.scan_last = idx_r == IW'(TABLE_DEPTH - 1);
  assign out_word      = out_r;

  assign h_age = clock_r - stamp_r[hit_r];
  assign upd   = hb_r[hit_r] < word_r.member_heartbeat && h_age <= {16'd0, fail_timeout};

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.emit && word_r.command == CMD_TICK) valid_nxt[idx_r] = 1'b0;
    if (cmd.fin_merge && !hit_found_r && free_found_r) valid_nxt[free_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      clock_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (cmd.fin_tick) clock_r <= clock_r + 32'd1;
      if (cmd.emit && word_r.command == CMD_TICK) count_r <= count_r - CNT_W'(1);
      else if (cmd.fin_merge && !hit_found_r && free_found_r)
        count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r       <= in_word;
      idx_r        <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      fin_cnt_r    <= count_r;
    end
    if (cmd.count) begin
      if (slot_hit) fin_cnt_r <= fin_cnt_r - CNT_W'(1);
      // rewind for the reporting pass
      idx_r <= sts.scan_last ? '0 : idx_r + IW'(1);
    end
    if (cmd.scan) begin
      if (word_r.command == CMD_MERGE) begin
        if (cur_valid && id_eq && !hit_found_r) begin
          hit_found_r <= 1'b1;
          hit_r       <= idx_r;
        end
        if (!cur_valid && !free_found_r) begin
          free_found_r <= 1'b1;
          free_r       <= idx_r;
        end
      end
      // hold index on a hit so emit reads the same slot
      if (!slot_hit && !sts.scan_last) idx_r <= idx_r + IW'(1);
    end
    if (cmd.emit && !sts.scan_last) idx_r <= idx_r + IW'(1);
    if (cmd.emit) begin
      out_r.status          <= (word_r.command == CMD_TICK) ? ST_REMOVED : ST_LIVE;
      out_r.entry_id        <= id_r[idx_r];
      out_r.entry_port      <= port_r[idx_r];
      out_r.entry_heartbeat <= hb_r[idx_r];
      // tick advances the clock at the end; its final count comes from the counting pass
      out_r.local_clock     <= (word_r.command == CMD_TICK) ? clock_r + 32'd1 : clock_r;
      out_r.member_count    <= (word_r.command == CMD_TICK) ? fin_cnt_r : count_r;
      out_r.last            <= 1'b0;
    end
    if (cmd.fin_merge) begin
      if (hit_found_r) begin
        out_r.status          <= upd ? ST_UPDATED : ST_UNCHANGED;
        out_r.entry_id        <= id_r[hit_r];
        out_r.entry_port      <= port_r[hit_r];
        out_r.entry_heartbeat <= upd ? word_r.member_heartbeat : hb_r[hit_r];
        if (upd) begin
          hb_r[hit_r]    <= word_r.member_heartbeat;
          stamp_r[hit_r] <= clock_r;
        end
      end else begin
        out_r.status          <= free_found_r ? ST_ADDED : ST_FULL;
        out_r.entry_id        <= word_r.member_id;
        out_r.entry_port      <= word_r.member_port;
        out_r.entry_heartbeat <= word_r.member_heartbeat;
        if (free_found_r) begin
          id_r[free_r]    <= word_r.member_id;
          port_r[free_r]  <= word_r.member_port;
          hb_r[free_r]    <= word_r.member_heartbeat;
          stamp_r[free_r] <= clock_r;
        end
      end
    end
    if (cmd.emit_done) begin
      if (word_r.command != CMD_MERGE) begin
        out_r.status          <= ST_DONE;
        out_r.entry_id        <= '0;
        out_r.entry_port      <= '0;
        out_r.entry_heartbeat <= '0;
      end
      out_r.local_clock  <= clock_r;
      out_r.member_count <= count_r;
      out_r.last         <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// File: src/heartbeat_membership_table_core.sv
// Scan: a merge or listing walks every slot, one per cycle, pausing whenever an entry
//   is reported; a tick first counts removals in a pass over every slot, then walks them again.
//   Each reported entry and each output stall delays the final word.
// Flow: one word at a time; the next word is accepted only after the final word
//   of the last has been taken by the consumer.
// Reset (rst_n, synchronous): all slots invalid, clock and count zero,
//   timeouts 5 and 20; no clearing pass.
`default_nettype none
module heartbeat_membership_table_core #(
  parameter int unsigned TABLE_DEPTH = hmt_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  hmt_in_if.sink           in_ch,
  hmt_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:2]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import hmt_pkg::*;

  logic [15:0] fail_r, remove_r;
  cmd_t cmd;
  sts_t sts;
  out_word_t ow;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {16'd0, (cfg_paddr[2] == ADDR_REMOVE) ? remove_r : fail_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_r   <= FAIL_RST;
      remove_r <= REMOVE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == ADDR_FAIL) fail_r <= cfg_pwdata[15:0];
      else remove_r <= cfg_pwdata[15:0];
    end
  end

  hmt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_command(in_ch.data.command),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  hmt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_ch.data), .cmd(cmd), .sts(sts),
    .out_word(ow), .fail_timeout(fail_r), .remove_timeout(remove_r)
  );

  assign out_ch.data = ow;
endmodule
`default_nettype wire
